/* rtl/spectrum_band_meter_peak_hold_top_defines.svh */
// ---------------------------------------------------------------------------
// Spectrum band meter assertion macros
// Checks fold away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_METER_PEAK_HOLD_TOP_DEFINES_SVH
`define SPECTRUM_BAND_METER_PEAK_HOLD_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SBMPH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbmph check failed");
`define SBMPH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sbmph check failed");
`else
`define SBMPH_ASSERT(lbl, prop)
`define SBMPH_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* rtl/sbmph_pkg.sv */
// ---------------------------------------------------------------------------
// Spectrum band meter package
// Widths, constants and operation codes of the band meter.
// ---------------------------------------------------------------------------
package sbmph_pkg;

  localparam int BANDS          = 32;
  localparam int BAND_W         = 5;
  localparam int SUM_W          = 48;
  localparam int DIV_W          = 32;
  localparam int LVL_W          = 5;
  localparam int CUT_W          = 16;
  localparam int SR_W           = 16;
  localparam int MAG_W          = 32;
  localparam int BIN_W          = 8;
  localparam int CFG_W          = 32;
  localparam int FFT_POINTS_DEF = 256;

  localparam int DIV_RESET   = 100;
  localparam int FULL_SCALE  = 30;
  localparam int BLEND_FIRST = 2;
  localparam int BLEND_LAST  = 10;
  localparam int SR_RESET    = 40000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BIN    = 2'd1,
    OP_END    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_NOISE_FLOOR = 1'b1
  } cfg_idx_t;

endpackage

/* rtl/sbmph_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sbmph_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/spectrum_band_meter_peak_hold_top.sv */
// ---------------------------------------------------------------------------
// Spectrum band meter with peak hold
// Accumulates magnitude bins into band sums and emits one bar word per band.
// ---------------------------------------------------------------------------
// Sequence: a cutoff load is taken while idle; a magnitude bin passes S_BAND
// and S_BADD, one memory read-modify-write of its band sum, and an ignored
// bin is dropped while idle. End of frame blends bands 2 to 10 in steps of
// two, settles each band (via S_DIV5 and S_ST_ADJ when the divider must grow),
// then sends each bar, via the shared restoring divider when the bar needs it.
// Throughput: one word at a time; the next word is taken once this one is
// done. Reset is synchronous: sums read 0, dividers 100 and peaks 0 at once.
`include "spectrum_band_meter_peak_hold_top_defines.svh"

module spectrum_band_meter_peak_hold_top
  import sbmph_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [BIN_W-1:0]  in_bin_index,
  input  logic [MAG_W-1:0]  in_magnitude,
  input  logic [BAND_W-1:0] in_table_index,
  input  logic [CUT_W-1:0]  in_cutoff_hz,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BAND_W-1:0] out_band_number,
  output logic [LVL_W-1:0]  out_bar_height,
  output logic [LVL_W-1:0]  out_peak_level,
  output logic              out_last_band
);

  // Half the FFT length is a power of two, so the bin frequency divide is
  // a plain shift.
  localparam int HALF     = FFT_POINTS / 2;
  localparam int LOG_HALF = $clog2(HALF);
  localparam int PROD_W   = BIN_W + SR_W - 1;
  localparam int Q5_W     = SUM_W - 4;
  localparam int REM_W    = SUM_W + 5;
  localparam int DEN_W    = DIV_W + LVL_W;
  localparam int ADJ_W    = Q5_W + 3;
  localparam int CNT_W    = 6;
  localparam logic [12:0]      HALF_V    = 13'(HALF);
  localparam logic [CNT_W-1:0] DIV_TOP   = CNT_W'(5);
  localparam logic [LVL_W-1:0] LVL_MAX   = '1;
  localparam logic [BAND_W-1:0] LAST_IDX = BAND_W'(BANDS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BAND, S_BADD, S_BL_A, S_BL_B, S_BL_C, S_ST_RD, S_ST_CHK,
    S_DIV5, S_ST_ADJ, S_ST_LVL, S_DIV, S_ST_WR, S_BR_RD, S_BR_MUL, S_BR_OUT
  } state_t;

  state_t state_r;

  logic [SR_W-1:0]  sample_rate_r;
  logic [MAG_W-1:0] noise_floor_r;

  logic [CUT_W-1:0] cutoff_r [BANDS];
  logic [LVL_W-1:0] peaks_r  [BANDS];
  logic [LVL_W-1:0] lvl_r    [BANDS];
  logic [BANDS-1:0] sum_vld_r;
  logic [BANDS-1:0] div_vld_r;
  logic             rd_sv_r;
  logic             rd_dv_r;

  logic [BAND_W-1:0] idx_r;
  logic [BAND_W-1:0] band_r;
  logic [MAG_W-1:0]  mag_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  a_sum_r;
  logic [DIV_W-1:0]  a_div_r;
  logic [SUM_W-1:0]  s_r;
  logic [DIV_W-1:0]  d_r;
  logic [Q5_W-1:0]   num5_r;
  logic [7:0]        fold5_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [LVL_W-1:0]  q_r;
  logic              div_bar_r;
  logic [LVL_W-1:0]  bar_r;
  logic [LVL_W-1:0]  m_r;

  logic              out_valid_r;
  logic [BAND_W-1:0] out_band_r;
  logic [LVL_W-1:0]  out_bar_r;
  logic [LVL_W-1:0]  out_peak_r;
  logic              out_last_r;

  // Memory ports
  logic              sum_we;
  logic [BAND_W-1:0] sum_waddr;
  logic [SUM_W-1:0]  sum_wdata;
  logic [SUM_W-1:0]  sum_rdata;
  logic              div_we;
  logic [BAND_W-1:0] div_waddr;
  logic [DIV_W-1:0]  div_wdata;
  logic [DIV_W-1:0]  div_rdata;
  logic [BAND_W-1:0] raddr;

  logic [PROD_W-1:0] prod_w;
  logic [CUT_W-1:0]  freq_w;
  logic [BAND_W-1:0] band_w;
  logic              bin_ok;
  logic              out_free;
  logic [SUM_W-1:0]  s_rd;
  logic [DIV_W-1:0]  d_rd;
  logic [DIV_W-1:0]  d_nz;
  logic              over;
  logic [SUM_W:0]    acc_sum;
  logic [SUM_W-1:0]  sum_sat;
  logic [SUM_W:0]    bl_sum;
  logic [DIV_W:0]    bl_div;
  logic [7:0]        nib_sum;
  logic [4:0]        fold2;
  logic [4:0]        fold_a;
  logic [4:0]        fold_b;
  logic [2:0]        mod5;
  logic [2:0]        pad5;
  logic [ADJ_W-1:0]  adj_sum;
  logic [DIV_W-1:0]  d_adj;
  logic [REM_W-1:0]  den_sh;
  logic              ge;
  logic              div_done;
  logic [LVL_W-1:0]  q_fin;
  logic [REM_W-1:0]  num30;

  sbmph_ram #(.W(SUM_W), .D(BANDS)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (raddr),
    .rdata (sum_rdata)
  );

  sbmph_ram #(.W(DIV_W), .D(BANDS)) u_div_ram (
    .clk   (clk),
    .we    (div_we),
    .waddr (div_waddr),
    .wdata (div_wdata),
    .raddr (raddr),
    .rdata (div_rdata)
  );

  // Entries never written since reset read as their reset values.
  assign s_rd = rd_sv_r ? sum_rdata : '0;
  assign d_rd = rd_dv_r ? div_rdata : DIV_W'(DIV_RESET);
  assign d_nz = (d_rd == '0) ? DIV_W'(1) : d_rd;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Bin frequency; the bin index lies at 2 or above whenever it is used.
  assign prod_w = PROD_W'(in_bin_index - BIN_W'(2)) * PROD_W'(sample_rate_r[SR_W-1:1]);
  assign freq_w = CUT_W'(prod_r >> LOG_HALF);
  assign bin_ok = (in_bin_index >= BIN_W'(2)) && ({5'b0, in_bin_index} < HALF_V) &&
                  (in_magnitude > noise_floor_r);

  // First band whose cutoff lies above the frequency, else the last band.
  always_comb begin
    band_w = LAST_IDX;
    for (int b = BANDS - 1; b >= 0; b--) begin
      if (freq_w < cutoff_r[b]) begin
        band_w = BAND_W'(b);
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_BAND:  raddr = band_w;
      S_BL_A:  raddr = idx_r - BAND_W'(1);
      S_BL_B:  raddr = idx_r + BAND_W'(1);
      default: raddr = idx_r;
    endcase
  end

  assign acc_sum = {1'b0, s_rd} + (SUM_W + 1)'(mag_r);
  assign sum_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
  assign bl_sum  = {1'b0, a_sum_r} + {1'b0, s_rd};
  assign bl_div  = {1'b0, a_div_r} + {1'b0, d_rd};

  // A band is over range when sum / divider exceeds 31.
  assign over = (s_rd >> 5) >= SUM_W'(d_nz);

  // The divider grows to the smallest value of the form divider + 5k that
  // covers the shortfall, so only the shortfall modulo five matters.
  // Sixteen is one modulo five, so the nibbles of the shortfall fold.
  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < Q5_W / 4; i++) begin
      nib_sum = nib_sum + 8'(num5_r[4*i +: 4]);
    end
  end

  assign fold2  = 5'(fold5_r[7:4]) + 5'(fold5_r[3:0]);
  assign fold_a = (fold2 >= 5'd20) ? fold2 - 5'd20 : fold2;
  assign fold_b = (fold_a >= 5'd10) ? fold_a - 5'd10 : fold_a;
  assign mod5   = (fold_b >= 5'd5) ? 3'(fold_b - 5'd5) : fold_b[2:0];
  assign pad5   = (mod5 == 3'd0) ? 3'd0 : 3'd5 - mod5;

  assign adj_sum = ADJ_W'(d_r) + ADJ_W'(num5_r) + ADJ_W'(pad5);
  assign d_adj   = (adj_sum > ADJ_W'({DIV_W{1'b1}})) ? '1 : adj_sum[DIV_W-1:0];

  // Shared restoring divider: a quotient of 32 or more saturates to 31.
  assign den_sh   = REM_W'(den_r) << cnt_r[2:0];
  assign ge       = (rem_r >= den_sh);
  assign div_done = ((cnt_r == DIV_TOP) && ge) || (cnt_r == '0);
  assign q_fin    = (cnt_r == DIV_TOP) ? LVL_MAX : {q_r[LVL_W-2:0], ge};

  assign num30 = (REM_W'(s_rd) << 5) - (REM_W'(s_rd) << 1);

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = idx_r;
    sum_wdata = '0;
    div_we    = 1'b0;
    div_waddr = idx_r;
    div_wdata = d_r;
    unique case (state_r)
      S_BADD: begin
        sum_we    = 1'b1;
        sum_waddr = band_r;
        sum_wdata = sum_sat;
      end
      S_BL_C: begin
        sum_we    = 1'b1;
        sum_wdata = bl_sum[SUM_W:1];
        div_we    = 1'b1;
        div_wdata = bl_div[DIV_W:1];
      end
      S_ST_WR: begin
        div_we = 1'b1;
      end
      S_BR_OUT: begin
        sum_we = out_free;
      end
      default: begin
      end
    endcase
  end

  // Control state, configuration, peaks and the output word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      sample_rate_r <= SR_W'(SR_RESET);
      noise_floor_r <= '0;
      sum_vld_r     <= '0;
      div_vld_r     <= '0;
      for (int b = 0; b < BANDS; b++) begin
        peaks_r[b] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SAMPLE_RATE: sample_rate_r <= cfg_wdata[SR_W-1:0];
          CFG_NOISE_FLOOR: noise_floor_r <= cfg_wdata[MAG_W-1:0];
        endcase
      end
      if (sum_we) begin
        sum_vld_r[sum_waddr] <= 1'b1;
      end
      if (div_we) begin
        div_vld_r[div_waddr] <= 1'b1;
      end
      // A new word is loaded when the register is free; a taken word clears.
      if ((state_r == S_BR_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_operation)
              OP_BIN:  state_r <= bin_ok ? S_BAND : S_IDLE;
              OP_END:  state_r <= S_BL_A;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_BAND:   state_r <= S_BADD;
        S_BADD:   state_r <= S_IDLE;
        S_BL_A:   state_r <= S_BL_B;
        S_BL_B:   state_r <= S_BL_C;
        S_BL_C:   state_r <= (idx_r == BAND_W'(BLEND_LAST)) ? S_ST_RD : S_BL_A;
        S_ST_RD:  state_r <= S_ST_CHK;
        S_ST_CHK: state_r <= over ? S_DIV5 : S_ST_LVL;
        S_DIV5:   state_r <= S_ST_ADJ;
        S_ST_ADJ: state_r <= S_ST_LVL;
        S_ST_LVL: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_r <= div_bar_r ? S_BR_OUT : S_ST_WR;
          end
        end
        S_ST_WR: begin
          if (q_r > peaks_r[idx_r]) begin
            peaks_r[idx_r] <= q_r;
          end
          state_r <= (idx_r == LAST_IDX) ? S_BR_RD : S_ST_RD;
        end
        S_BR_RD:  state_r <= S_BR_MUL;
        S_BR_MUL: state_r <= (m_r >= LVL_W'(FULL_SCALE)) ? S_BR_OUT : S_DIV;
        S_BR_OUT: begin
          if (out_free) begin
            out_band_r  <= idx_r;
            out_bar_r   <= bar_r;
            out_peak_r  <= peaks_r[idx_r];
            out_last_r  <= (idx_r == LAST_IDX);
            if (peaks_r[idx_r] != '0) begin
              peaks_r[idx_r] <= peaks_r[idx_r] - LVL_W'(1);
            end
            state_r <= (idx_r == LAST_IDX) ? S_IDLE : S_BR_RD;
          end
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_sv_r <= sum_vld_r[raddr];
    rd_dv_r <= div_vld_r[raddr];
    unique case (state_r)
      S_IDLE: begin
        mag_r  <= in_magnitude;
        prod_r <= prod_w;
        idx_r  <= BAND_W'(BLEND_FIRST);
        m_r    <= LVL_W'(1);
        if (in_valid && (in_operation == OP_LOAD)) begin
          cutoff_r[in_table_index] <= in_cutoff_hz;
        end
      end
      S_BAND: band_r <= band_w;
      S_BL_B: begin
        a_sum_r <= s_rd;
        a_div_r <= d_rd;
      end
      S_BL_C: begin
        idx_r <= (idx_r == BAND_W'(BLEND_LAST)) ? '0 : idx_r + BAND_W'(2);
      end
      S_ST_CHK: begin
        s_r    <= s_rd;
        d_r    <= d_nz;
        // Divider shortfall: sum/32 + 1 - divider.
        num5_r <= Q5_W'(s_rd >> 5) + Q5_W'(1) - Q5_W'(d_nz);
      end
      S_DIV5:   fold5_r <= nib_sum;
      S_ST_ADJ: d_r <= d_adj;
      S_ST_LVL: begin
        rem_r     <= REM_W'(s_r);
        den_r     <= DEN_W'(d_r);
        q_r       <= '0;
        cnt_r     <= DIV_TOP;
        div_bar_r <= 1'b0;
      end
      S_DIV: begin
        if (div_done) begin
          q_r   <= q_fin;
          bar_r <= q_fin;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r != DIV_TOP) begin
            q_r <= q_fin;
            if (ge) begin
              rem_r <= rem_r - den_sh;
            end
          end
        end
      end
      S_ST_WR: begin
        lvl_r[idx_r] <= q_r;
        m_r          <= (q_r > m_r) ? q_r : m_r;
        idx_r        <= idx_r + BAND_W'(1);
      end
      S_BR_MUL: begin
        bar_r     <= lvl_r[idx_r];
        rem_r     <= num30;
        den_r     <= DEN_W'(m_r) * DEN_W'(d_rd);
        q_r       <= '0;
        cnt_r     <= DIV_TOP;
        div_bar_r <= 1'b1;
      end
      S_BR_OUT: begin
        if (out_free) begin
          idx_r <= idx_r + BAND_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_band_number = out_band_r;
  assign out_bar_height  = out_bar_r;
  assign out_peak_level  = out_peak_r;
  assign out_last_band   = out_last_r;

  // Settled dividers are never zero when the bars are scaled.
  `SBMPH_ASSERT(a_bar_div_nonzero, (state_r == S_BR_MUL) |-> (d_rd != '0))
  // Sending the last band word closes the frame.
  `SBMPH_ASSERT_NEXT(a_frame_ends_idle, (state_r == S_BR_OUT) && out_free && (idx_r == LAST_IDX), state_r == S_IDLE)

endmodule
